[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on i_clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that an antecedent implies a consequent on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/cmhc_pkg.sv]
// ----------------------------------------------------------------------------
// cmhc_pkg
// Types and constants of the clock motor homing controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cmhc_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_FWD   = 2'd1;
    localparam logic [1:0] OP_BWD   = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    localparam logic [2:0] MODE_STOPPED     = 3'd0;
    localparam logic [2:0] MODE_FORWARD     = 3'd1;
    localparam logic [2:0] MODE_BACKWARD    = 3'd2;
    localparam logic [2:0] MODE_CALIBRATING = 3'd3;
    localparam logic [2:0] MODE_FIND        = 3'd4;

    localparam logic [7:0] ALL_SWITCHES      = 8'hFF;
    localparam logic [7:0] HOME_HOUR_PATTERN = 8'h90;
    localparam logic [7:0] HOME_MINUTE_BIT   = 8'h02;
    localparam logic [7:0] HOME_PATTERN      = HOME_HOUR_PATTERN | HOME_MINUTE_BIT;

    localparam logic [7:0] SPEED_RESET = 8'd1;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] raw_switch_row;
    } t_in_item;

    typedef struct packed {
        logic       drive_forward;
        logic       drive_reverse;
        logic [2:0] mode_now;
        logic [7:0] change_count;
        logic [7:0] seen_on_mask;
        logic [7:0] seen_off_mask;
    } t_out_item;

    typedef struct packed {
        logic [7:0] switches_now;
        logic [2:0] mode;
        logic [7:0] countdown;
        logic [7:0] seen_on;
        logic [7:0] seen_off;
        logic [7:0] changes;
        logic       fwd_drive;
        logic       rev_drive;
    } t_state;

    localparam t_state STATE_RESET = '{
        switches_now: 8'd0,
        mode:         MODE_CALIBRATING,
        countdown:    8'd1,
        seen_on:      8'd0,
        seen_off:     8'd0,
        changes:      8'd0,
        fwd_drive:    1'b0,
        rev_drive:    1'b0
    };

endpackage

`default_nettype wire

[hw/rtl/clock_motor_homing_controller_core.sv]
// ----------------------------------------------------------------------------
// clock_motor_homing_controller_core
// Clock motor homing controller: mode control, opto tracking, drive pulsing.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  in       | input     | i_in_valid/o_in_stall  | i_in_data  (t_in_item)
//  out      | output    | o_out_valid/i_out_stall| o_out_data (t_out_item)
//  cfg      | input     | i_cfg_valid/o_cfg_ready| i_cfg_data (speed divider)
//
//  One transaction per cycle sustained unless i_out_stall holds a result;
//  items pass the input register, then state update into the result register.
//  The state update is a single pass through cmhc_step.
//  Synchronous active-low reset; calibration mode, speed divider 1.
//  A stalled result holds; the input register keeps accepting while the
//  result register drains in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_motor_homing_controller_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire cmhc_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output cmhc_pkg::t_out_item       o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [7:0]           i_cfg_data
);
    import cmhc_pkg::*;

    `include "assert_macros.svh"

    logic       r_in_valid;
    t_in_item   r_in_data;
    logic       r_out_valid;
    t_out_item  r_out_data;
    t_state     r_state;
    t_state     n_state;
    logic [7:0] r_speed;
    logic       w_adv;

    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    cmhc_step u_step (
        .i_state (r_state),
        .i_item  (r_in_data),
        .i_speed (r_speed),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
            r_speed     <= SPEED_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_speed <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (w_adv) begin
            r_out_data.drive_forward <= n_state.fwd_drive;
            r_out_data.drive_reverse <= n_state.rev_drive;
            r_out_data.mode_now      <= n_state.mode;
            r_out_data.change_count  <= n_state.changes;
            r_out_data.seen_on_mask  <= n_state.seen_on;
            r_out_data.seen_off_mask <= n_state.seen_off;
        end
    end

    `ASSERT_CLK(a_drive_excl, !(r_state.fwd_drive && r_state.rev_drive),
        "both motor drives on")
    `ASSERT_NEXT(a_adv_result, w_adv, r_out_valid,
        "advanced transaction produced no result")
    `ASSERT_NEXT(a_state_hold, !w_adv, $stable(r_state),
        "state changed without a transaction")

endmodule

`default_nettype wire

[hw/rtl/cmhc_step.sv]
// ----------------------------------------------------------------------------
// cmhc_step
// Next-state logic for one command or tick transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cmhc_step (
    input  wire cmhc_pkg::t_state   i_state,
    input  wire cmhc_pkg::t_in_item i_item,
    input  wire logic [7:0]         i_speed,
    output cmhc_pkg::t_state        o_state
);
    import cmhc_pkg::*;

    logic [7:0] w_sw;
    logic [7:0] w_seen_on;
    logic [7:0] w_seen_off;
    logic [7:0] w_cd_dec;
    logic       w_pulse;

    assign w_sw       = ~i_item.raw_switch_row;
    assign w_seen_on  = i_state.seen_on | w_sw;
    assign w_seen_off = i_state.seen_off | ~w_sw;
    assign w_pulse    = (i_state.countdown == i_speed);
    assign w_cd_dec   = i_state.countdown - 8'd1;

    always_comb begin
        o_state = i_state;
        unique case (i_item.operation)
            OP_TICK: begin
                o_state.switches_now = w_sw;
                o_state.seen_on      = w_seen_on;
                o_state.seen_off     = w_seen_off;
                if (w_sw != i_state.switches_now) begin
                    o_state.changes = i_state.changes + 8'd1;
                end
                o_state.countdown = (w_cd_dec == 8'd0) ? i_speed : w_cd_dec;
                unique case (i_state.mode)
                    MODE_FORWARD: begin
                        o_state.fwd_drive = w_pulse;
                        o_state.rev_drive = 1'b0;
                    end
                    MODE_BACKWARD: begin
                        o_state.fwd_drive = 1'b0;
                        o_state.rev_drive = w_pulse;
                    end
                    MODE_CALIBRATING: begin
                        if ((w_seen_on & w_seen_off) == ALL_SWITCHES) begin
                            o_state.mode = MODE_FIND;
                        end else begin
                            o_state.fwd_drive = 1'b1;
                            o_state.rev_drive = 1'b0;
                        end
                    end
                    MODE_FIND: begin
                        o_state.fwd_drive = 1'b0;
                        if (w_sw == HOME_PATTERN) begin
                            o_state.mode      = MODE_STOPPED;
                            o_state.rev_drive = 1'b0;
                        end else begin
                            o_state.rev_drive = w_pulse;
                        end
                    end
                    default: begin
                        o_state.fwd_drive = 1'b0;
                        o_state.rev_drive = 1'b0;
                    end
                endcase
            end
            OP_FWD:  o_state.mode = MODE_FORWARD;
            OP_BWD:  o_state.mode = MODE_BACKWARD;
            default: o_state.mode = MODE_STOPPED;
        endcase
    end

endmodule

`default_nettype wire
